[rtl/cso_pkg.sv]
package cso_pkg;

   // Default sizes of the bank
   localparam int unsigned DEF_NUM_OSC      = 1024;
   localparam int unsigned DEF_SINE_ENTRIES = 1024;
   localparam int unsigned DEF_PHASE_BITS   = 32;

   // Field widths
   localparam int unsigned OSC_INDEX_W   = 10;
   localparam int unsigned START_PHASE_W = 32;
   localparam int unsigned DETUNE_W      = 21;
   localparam int unsigned CLIP_W        = 15;
   localparam int unsigned SAMPLE_W      = 16;
   localparam int unsigned SUM_W         = 26;
   localparam int unsigned BASE_STEP_W   = 31;
   localparam int unsigned GAIN_W        = 16;
   localparam int unsigned ACTIVE_W      = 11;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 31;

   // Shared multiplier: 33 x 17 signed
   localparam int unsigned MUL_A_W = 33;
   localparam int unsigned MUL_B_W = 17;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

   // Register reset values
   localparam logic [BASE_STEP_W-1:0] RST_LEFT_STEP  = 31'd12738023;
   localparam logic [BASE_STEP_W-1:0] RST_RIGHT_STEP = 31'd25475934;
   localparam logic [GAIN_W-1:0]      RST_GAIN       = 16'd350;
   localparam logic [ACTIVE_W-1:0]    RST_ACTIVE     = 11'd1000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_STEP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_STEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE     = 2'd3;

   // Request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

endpackage

[rtl/clipped_sine_oscillator_bank.sv]
// Stereo bank of phase-accumulator oscillators. A load word (tuser 0) writes one oscillator's
// start phase, detune step and clip level. A tick word (tuser 1) steps every active
// oscillator (even ones on the left base step, odd ones on the right), looks up a clipped
// Q1.15 sine for each, sums the two channels and returns one stereo word scaled by
// output_gain and saturated to 16 bits. With N the active_count rounded down to even and
// capped at the bank size, a tick holds req_tready low until it is done: the N oscillators
// stream one per cycle through a single phase adder, the shared 33x17 multiplier and the
// sine ROM, the pipeline drains, and the two channel sums then reuse the multiplier for the
// gain in states MUL_L, MUL_R and FIN. The response word is valid in the cycle after FIN is
// left; a response still waiting at the end of the next tick holds that tick in its last
// cycle until the word is taken. Entries must be loaded before a tick reads them; the
// tables have no clearing pass after reset.
module clipped_sine_oscillator_bank
   import cso_pkg::*;
#(
   parameter int unsigned NUM_OSC      = DEF_NUM_OSC,
   parameter int unsigned SINE_ENTRIES = DEF_SINE_ENTRIES,
   parameter int unsigned PHASE_BITS   = DEF_PHASE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = osc_index[9:0], start_phase[41:10], detune_step[62:42],
   //          clip_level[77:63], zero pad[79:78]; tuser = kind
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   // response: tdata = left_sample[15:0], right_sample[31:16]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned OSC_AW     = $clog2(NUM_OSC);
   localparam int unsigned SINE_AW    = $clog2(SINE_ENTRIES);
   localparam int unsigned MAX_ACTIVE = 2 * (NUM_OSC / 2);
   localparam int unsigned OSC_CW     = $clog2(MAX_ACTIVE + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_MUL_L = 3'd2;
   localparam logic [2:0] ST_MUL_R = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   // ---------------------------------------------------------------- registers
   logic [BASE_STEP_W-1:0] left_step_ff, right_step_ff;
   logic [GAIN_W-1:0]      gain_ff;
   logic [ACTIVE_W-1:0]    active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_step_ff  <= RST_LEFT_STEP;
         right_step_ff <= RST_RIGHT_STEP;
         gain_ff       <= RST_GAIN;
         active_ff     <= RST_ACTIVE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEFT_STEP:  left_step_ff  <= csr_data;
            CSR_RIGHT_STEP: right_step_ff <= csr_data;
            CSR_GAIN:       gain_ff       <= csr_data[GAIN_W-1:0];
            CSR_ACTIVE:     active_ff     <= csr_data[ACTIVE_W-1:0];
            default:        ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- request fields
   logic [OSC_INDEX_W-1:0]   req_osc_index;
   logic [START_PHASE_W-1:0] req_start_phase;
   logic [DETUNE_W-1:0]      req_detune;
   logic [CLIP_W-1:0]        req_clip;

   assign req_osc_index   = req_tdata[9:0];
   assign req_start_phase = req_tdata[41:10];
   assign req_detune      = req_tdata[62:42];
   assign req_clip        = req_tdata[77:63];

   logic [2:0] state_ff, state_in;
   logic       req_accept, tick_accept, load_we;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign tick_accept = req_accept && (req_tuser == KIND_TICK);
   assign load_we     = req_accept && (req_tuser == KIND_LOAD)
                        && (32'(req_osc_index) < NUM_OSC);

   // Oscillators per tick: even, capped at the bank size
   logic [ACTIVE_W-1:0] active_even;
   logic [OSC_CW-1:0]   osc_total;

   assign active_even = {active_ff[ACTIVE_W-1:1], 1'b0};
   assign osc_total   = (32'(active_even) > MAX_ACTIVE) ? OSC_CW'(MAX_ACTIVE)
                                                        : OSC_CW'(active_even);

   // ---------------------------------------------------------------- tables
   logic [OSC_CW-1:0]     issue_ff, issue_in;
   logic                  issue_en;
   logic [OSC_AW-1:0]     rd_addr;
   logic [PHASE_BITS-1:0] ph_rd;
   logic [DETUNE_W-1:0]   det_rd;
   logic [CLIP_W-1:0]     clip_rd;

   logic                  ph_we;
   logic [OSC_AW-1:0]     ph_waddr;
   logic [PHASE_BITS-1:0] ph_wdata;

   logic                  b_valid_ff;
   logic                  b_side_ff;
   logic [OSC_AW-1:0]     b_addr_ff;
   logic [PHASE_BITS-1:0] b_phase_ff;
   logic [CLIP_W-1:0]     b_clip_ff;

   assign rd_addr  = issue_ff[OSC_AW-1:0];
   assign ph_we    = load_we || b_valid_ff;
   assign ph_waddr = b_valid_ff ? b_addr_ff : OSC_AW'(req_osc_index);
   assign ph_wdata = b_valid_ff ? b_phase_ff : req_start_phase[PHASE_BITS-1:0];

   cso_ram #(.WIDTH(PHASE_BITS), .DEPTH(NUM_OSC)) u_phase_ram (
      .clock   (clock),
      .wr_en   (ph_we),
      .wr_addr (ph_waddr),
      .wr_data (ph_wdata),
      .rd_addr (rd_addr),
      .rd_data (ph_rd)
   );

   cso_ram #(.WIDTH(DETUNE_W), .DEPTH(NUM_OSC)) u_detune_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (OSC_AW'(req_osc_index)),
      .wr_data (req_detune),
      .rd_addr (rd_addr),
      .rd_data (det_rd)
   );

   cso_ram #(.WIDTH(CLIP_W), .DEPTH(NUM_OSC)) u_clip_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (OSC_AW'(req_osc_index)),
      .wr_data (req_clip),
      .rd_addr (rd_addr),
      .rd_data (clip_rd)
   );

   // ---------------------------------------------------------------- oscillator pipeline
   // A: table data back; B: new phase held, written back, multiplied;
   // C: sine ROM lookup; D: clip and accumulate.
   logic              a_valid_ff, c_valid_ff, d_valid_ff;
   logic              a_side_ff, c_side_ff, d_side_ff;
   logic [OSC_AW-1:0] a_addr_ff;
   logic [CLIP_W-1:0] c_clip_ff, d_clip_ff;

   logic [BASE_STEP_W-1:0] a_base;
   logic [MUL_A_W-1:0]     phase_sum;

   assign a_base    = a_side_ff ? right_step_ff : left_step_ff;
   assign phase_sum = MUL_A_W'(ph_rd) + MUL_A_W'(a_base) + MUL_A_W'($signed(det_rd));

   assign issue_en = (state_ff == ST_RUN) && (issue_ff != osc_total);
   assign issue_in = tick_accept ? '0 : (issue_en ? issue_ff + 1'b1 : issue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         issue_ff   <= '0;
      end else begin
         a_valid_ff <= issue_en;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         issue_ff   <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff  <= issue_ff[0];
      a_addr_ff  <= rd_addr;
      b_side_ff  <= a_side_ff;
      b_addr_ff  <= a_addr_ff;
      b_phase_ff <= phase_sum[PHASE_BITS-1:0];
      b_clip_ff  <= clip_rd;
      c_side_ff  <= b_side_ff;
      c_clip_ff  <= b_clip_ff;
      d_side_ff  <= c_side_ff;
      d_clip_ff  <= c_clip_ff;
   end

   // ---------------------------------------------------------------- shared multiplier
   logic signed [SUM_W-1:0]   left_sum_ff, left_sum_in;
   logic signed [SUM_W-1:0]   right_sum_ff, right_sum_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;

   always_comb begin
      case (state_ff)
         ST_MUL_L: begin
            mul_a = MUL_A_W'(left_sum_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         ST_MUL_R, ST_FIN: begin
            mul_a = MUL_A_W'(right_sum_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = $signed(MUL_A_W'(b_phase_ff));
            mul_b = $signed(MUL_B_W'(SINE_ENTRIES));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // ---------------------------------------------------------------- sine and clip
   logic signed [SAMPLE_W-1:0] sine_rd;
   logic signed [SAMPLE_W:0]   sine_ext, clip_pos, clipped;

   cso_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine_rom (
      .clock   (clock),
      .rd_addr (prod_ff[PHASE_BITS +: SINE_AW]),
      .rd_data (sine_rd)
   );

   assign sine_ext = (SAMPLE_W + 1)'(sine_rd);
   assign clip_pos = $signed({2'b00, d_clip_ff});

   always_comb begin
      if (sine_ext > 0 && sine_ext > clip_pos) begin
         clipped = 17'sd32768;
      end else if (sine_ext < 0 && sine_ext < -clip_pos) begin
         clipped = -17'sd32768;
      end else begin
         clipped = sine_ext;
      end
   end

   always_comb begin
      left_sum_in  = left_sum_ff;
      right_sum_in = right_sum_ff;
      if (tick_accept) begin
         left_sum_in  = '0;
         right_sum_in = '0;
      end else if (d_valid_ff) begin
         if (d_side_ff) begin
            right_sum_in = right_sum_ff + SUM_W'(clipped);
         end else begin
            left_sum_in = left_sum_ff + SUM_W'(clipped);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
      end else begin
         left_sum_ff  <= left_sum_in;
         right_sum_ff <= right_sum_in;
      end
   end

   // ---------------------------------------------------------------- gain and saturation
   // Divide by 2^15 toward zero, then clamp to 16 bits
   function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = p >>> 15;
      if (p < 0 && p[14:0] != '0) begin
         q = q + 1;
      end
      if (q > 32767) begin
         return 16'h7FFF;
      end else if (q < -32768) begin
         return 16'h8000;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   logic [SAMPLE_W-1:0]   left_out_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL_R) begin
         left_out_ff <= scale_sat(prod_ff);
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_data_ff <= {scale_sat(prod_ff), left_out_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FIN && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- sequencer
   logic pipe_busy;

   assign pipe_busy = a_valid_ff || b_valid_ff || c_valid_ff || d_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_ff == osc_total && !pipe_busy) begin
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_pipe_only_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !pipe_busy)
      else $error("oscillator pipeline active outside a tick");

   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> issue_ff <= osc_total)
      else $error("issue counter ran past the active oscillator count");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(load_we && b_valid_ff))
      else $error("load write collides with phase write-back");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> state_ff == ST_RUN && left_sum_ff == 0 && right_sum_ff == 0
                      && issue_ff == 0)
      else $error("tick did not start from cleared sums");

endmodule

[rtl/cso_ram.sv]
module cso_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cso_sine_rom.sv]
module cso_sine_rom
   import cso_pkg::*;
#(
   parameter int unsigned SINE_ENTRIES = DEF_SINE_ENTRIES
) (
   input  logic                            clock,
   input  logic [$clog2(SINE_ENTRIES)-1:0] rd_addr,
   output logic signed [SAMPLE_W-1:0]      rd_data
);

   localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Q1.15 sine of table entry idx, polynomial evaluated at elaboration
   function automatic logic signed [SAMPLE_W-1:0] sine_at(input int unsigned idx);
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      logic [1:0]  quad;
      f    = (64'(idx) << 32) / SINE_ENTRIES;
      quad = f[31:30];
      r    = f & (Q30_ONE - 64'd1);
      if (quad[0]) begin
         r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + 64'h2000_0000) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
   endfunction

   logic signed [SAMPLE_W-1:0] rom_w [SINE_ENTRIES];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
      assign rom_w[g] = sine_at(g);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_w[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/tb_clipped_sine_oscillator_bank.sv]
module tb_clipped_sine_oscillator_bank;
   import cso_pkg::*;

   // Slowest legal run: every word a full-bank tick plus the longest stalls, taken a few times
   localparam int unsigned LIMIT        = 8_000_000;
   localparam int          RANDOM_WORDS = 580;
   localparam logic [63:0] Q30_ONE      = 64'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

   // Same bit order as req_tuser/req_tdata: osc_index lowest
   typedef struct packed {
      logic                     kind;
      logic [CLIP_W-1:0]        clip;
      logic [DETUNE_W-1:0]      detune;
      logic [START_PHASE_W-1:0] phase;
      logic [OSC_INDEX_W-1:0]   osc;
   } osc_word_t;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } frame_t;

   localparam int WORD_W = $bits(osc_word_t);

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   clipped_sine_oscillator_bank u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   osc_word_t words_to_send [$];
   frame_t    frames_due [$];
   bit        osc_loaded [DEF_NUM_OSC];
   int        words_sent  = 0;
   int        frames_seen = 0;
   int        errors      = 0;
   int        cycle_count = 0;
   int        stall_left  = 0;
   bit        stall_done  = 1'b0;
   logic      steady;

   // Predicted bank state and register copy
   logic [START_PHASE_W-1:0] acc_phase  [DEF_NUM_OSC];
   logic [DETUNE_W-1:0]      acc_detune [DEF_NUM_OSC];
   logic [CLIP_W-1:0]        acc_clip   [DEF_NUM_OSC];
   logic [BASE_STEP_W-1:0]   cur_left_step;
   logic [BASE_STEP_W-1:0]   cur_right_step;
   logic [GAIN_W-1:0]        cur_gain;
   logic [ACTIVE_W-1:0]      cur_active;

   assign steady = (words_sent >= 300) && (words_sent < 420);

   function automatic int sine_q15(logic [START_PHASE_W-1:0] ph);
      logic [63:0] idx, f, r, x, x2, t, s, v;
      idx = (64'(ph) * 64'(DEF_SINE_ENTRIES)) >> DEF_PHASE_BITS;
      f   = (idx << 32) / 64'(DEF_SINE_ENTRIES);
      r   = f & (Q30_ONE - 64'd1);
      // mirror the remainder in odd quadrants
      if (f[30])
         r = Q30_ONE - r;
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + 64'h2000_0000) >> 30;
      if (v > 64'd32767)
         v = 64'd32767;
      return f[31] ? -int'(v) : int'(v);
   endfunction

   function automatic int advance_osc(int n, logic [BASE_STEP_W-1:0] base);
      logic [START_PHASE_W-1:0] step;
      int v, c;
      step = {1'b0, base} + {{(START_PHASE_W-DETUNE_W){acc_detune[n][DETUNE_W-1]}},
                             acc_detune[n]};
      acc_phase[n] = acc_phase[n] + step;
      v = sine_q15(acc_phase[n]);
      c = int'(acc_clip[n]);
      if (v > 0 && v > c)
         return 32768;
      if (v < 0 && v < -c)
         return -32768;
      return v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] scale_sum(int sum);
      longint y;
      y = longint'(sum) * longint'(cur_gain) / 32768;
      if (y > 32767)
         y = 32767;
      if (y < -32768)
         y = -32768;
      return y[SAMPLE_W-1:0];
   endfunction

   function automatic void predict_word(osc_word_t w);
      int pairs, ls, rs;
      frame_t fr;
      if (w.kind == KIND_LOAD) begin
         acc_phase[w.osc]  = w.phase;
         acc_detune[w.osc] = w.detune;
         acc_clip[w.osc]   = w.clip;
      end else begin
         pairs = int'(cur_active >> 1);
         if (pairs > int'(DEF_NUM_OSC / 2))
            pairs = int'(DEF_NUM_OSC / 2);
         ls = 0;
         rs = 0;
         for (int p = 0; p < pairs; p++) begin
            ls += advance_osc(2 * p, cur_left_step);
            rs += advance_osc(2 * p + 1, cur_right_step);
         end
         fr.left  = scale_sum(ls);
         fr.right = scale_sum(rs);
         frames_due.push_back(fr);
      end
   endfunction

   // Check results first, then apply register writes and accepted words
   always @(posedge clock) begin : monitor
      frame_t fr;
      if (reset) begin
         cur_left_step  = RST_LEFT_STEP;
         cur_right_step = RST_RIGHT_STEP;
         cur_gain       = RST_GAIN;
         cur_active     = RST_ACTIVE;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            frames_seen <= frames_seen + 1;
            if (frames_due.size() == 0) begin
               $error("frame %h with no tick waiting", rsp_tdata);
               errors++;
            end else begin
               fr = frames_due.pop_front();
               if (rsp_tdata[15:0] !== fr.left) begin
                  $error("left_sample: expected %0d, got %0d", fr.left,
                         $signed(rsp_tdata[15:0]));
                  errors++;
               end
               if (rsp_tdata[31:16] !== fr.right) begin
                  $error("right_sample: expected %0d, got %0d", fr.right,
                         $signed(rsp_tdata[31:16]));
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEFT_STEP:  cur_left_step  = csr_data[BASE_STEP_W-1:0];
               CSR_RIGHT_STEP: cur_right_step = csr_data[BASE_STEP_W-1:0];
               CSR_GAIN:       cur_gain       = csr_data[GAIN_W-1:0];
               CSR_ACTIVE:     cur_active     = csr_data[ACTIVE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            words_sent <= words_sent + 1;
            predict_word({req_tuser, req_tdata[77:0]});
         end
      end
   end

   always @(posedge clock) begin : driver
      osc_word_t w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (words_to_send.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
            w = words_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= w.kind;
            req_tdata  <= {2'b00, w.clip, w.detune, w.phase, w.osc};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!stall_done && frames_seen >= 40 && words_to_send.size() >= 10) begin
         // hold off long enough for the bank to back up into its input
         stall_done <= 1'b1;
         stall_left <= 1200;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= 33;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (words_to_send.size() != 0 || req_tvalid || frames_due.size() != 0)
         @(negedge clock);
      // let a trailing load word settle before any register write
      repeat (32) @(negedge clock);
   endtask

   function automatic void load_word(int idx, logic [START_PHASE_W-1:0] ph,
                                     logic [DETUNE_W-1:0] det, logic [CLIP_W-1:0] clip);
      osc_word_t w;
      w.kind   = KIND_LOAD;
      w.osc    = idx[OSC_INDEX_W-1:0];
      w.phase  = ph;
      w.detune = det;
      w.clip   = clip;
      osc_loaded[idx] = 1'b1;
      words_to_send.push_back(w);
   endfunction

   function automatic void random_load(int idx);
      logic [DETUNE_W-1:0] det;
      logic [CLIP_W-1:0]   clip;
      case ($urandom_range(3))
         0:       det = DETUNE_W'($urandom_range(0, 2000)) - DETUNE_W'(1000);
         default: det = DETUNE_W'($urandom);
      endcase
      case ($urandom_range(4))
         0:       clip = '0;
         1:       clip = '1;
         2:       clip = CLIP_W'($urandom_range(16000, 32767));
         default: clip = CLIP_W'($urandom);
      endcase
      load_word(idx, $urandom, det, clip);
   endfunction

   function automatic void tick_word();
      osc_word_t w;
      w      = WORD_W'({$urandom, $urandom, $urandom});
      w.kind = KIND_TICK;
      words_to_send.push_back(w);
   endfunction

   function automatic logic [BASE_STEP_W-1:0] pick_step();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2:       return BASE_STEP_W'($urandom_range(0, 1 << 20));
         default: return BASE_STEP_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int phase_no, count, act, need, sent_random;
      logic [GAIN_W-1:0] gain;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes of every field, clip zero, both saturation signs
      write_reg(CSR_LEFT_STEP, '0);
      write_reg(CSR_RIGHT_STEP, 31'h7FFF_FFFF);
      write_reg(CSR_GAIN, 31'(16'hFFFF));
      write_reg(CSR_ACTIVE, 31'(4));
      load_word(0, 32'h0000_0000, 21'h000000, 15'h0000);
      load_word(1, 32'hFFFF_FFFF, 21'h0FFFFF, 15'h7FFF);
      load_word(2, 32'h4000_0000, 21'h000000, 15'h0000);
      load_word(3, 32'h8000_0000, 21'h100000, 15'h0000);
      load_word(1023, 32'hA5A5_5A5A, 21'h0F0F0, 15'h4000);
      tick_word();
      tick_word();
      load_word(0, 32'h4000_0000, 21'h000000, 15'h0000);
      load_word(2, 32'h4000_0000, 21'h000000, 15'd100);
      tick_word();
      load_word(0, 32'hC000_0000, 21'h000000, 15'h0000);
      load_word(2, 32'hC000_0000, 21'h000000, 15'h7FFF);
      tick_word();
      load_word(0, 32'h0000_0000, 21'h000000, 15'h7FFF);
      load_word(2, 32'h0000_0000, 21'h000000, 15'h0000);
      tick_word();
      wait_idle();

      // Random phases, each with its own register settings
      phase_no    = 0;
      sent_random = 0;
      while (sent_random < RANDOM_WORDS - 30) begin
         case ($urandom_range(9))
            0:       act = $urandom_range(0, 1);
            1:       act = 2;
            2:       act = 2 * $urandom_range(1, 32) + 1;
            3:       act = $urandom_range(65, 256);
            default: act = 2 * $urandom_range(1, 24);
         endcase
         case ($urandom_range(4))
            0:       gain = '0;
            1:       gain = '1;
            2:       gain = GAIN_W'($urandom);
            default: gain = GAIN_W'($urandom_range(0, 1000));
         endcase
         write_reg(CSR_LEFT_STEP, pick_step());
         write_reg(CSR_RIGHT_STEP, pick_step());
         write_reg(CSR_GAIN, 31'(gain));
         write_reg(CSR_ACTIVE, 31'(act));
         need = act & ~1;
         for (int i = 0; i < need; i++)
            if (!osc_loaded[i])
               random_load(i);
         count = $urandom_range(30, 60);
         for (int n = 0; n < count; n++) begin
            if (phase_no == 2 && n == count / 2)
               wait_idle();
            if ($urandom_range(99) < 40) begin
               if (need > 0 && $urandom_range(99) < 70)
                  random_load($urandom_range(0, need - 1));
               else
                  random_load($urandom_range(0, DEF_NUM_OSC - 1));
            end else begin
               tick_word();
            end
            sent_random++;
         end
         wait_idle();
         phase_no++;
      end

      // Whole bank: full count, counts past the bank size, odd counts
      for (int i = 0; i < int'(DEF_NUM_OSC); i++)
         if (!osc_loaded[i])
            random_load(i);
      wait_idle();
      for (int k = 0; k < 4; k++) begin
         case (k)
            0:       act = 1024;
            1:       act = 2047;
            2:       act = 1023;
            default: act = 1537;
         endcase
         write_reg(CSR_LEFT_STEP, pick_step());
         write_reg(CSR_RIGHT_STEP, pick_step());
         write_reg(CSR_GAIN, 31'($urandom_range(0, 400)));
         write_reg(CSR_ACTIVE, 31'(act));
         tick_word();
         for (int n = 0; n < 3; n++)
            random_load($urandom_range(0, DEF_NUM_OSC - 1));
         tick_word();
         wait_idle();
      end

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
rtl/cso_pkg.sv
rtl/cso_ram.sv
rtl/cso_sine_rom.sv
rtl/clipped_sine_oscillator_bank.sv
test/tb_clipped_sine_oscillator_bank.sv
